@@ rtl/core/lifp_pkg.sv @@
`default_nettype none
package lifp_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned V_W         = 16;
  localparam int unsigned G_W         = 16;
  localparam int unsigned DRV_W       = 16;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam int unsigned NEURONS_DEF   = 1024;
  localparam int unsigned TAB_DEPTH_DEF = 256;

  localparam logic signed [V_W-1:0] V_INIT  = -16'sd14080;
  localparam logic signed [V_W-1:0] VI_Q    = -16'sd17920;
  localparam logic [SUM_W-1:0]      SUM_MAX = '1;

  localparam logic signed [15:0] THRESH_RST = -16'sd12800;
  localparam logic signed [15:0] RESET_V_RST = -16'sd14080;
  localparam logic [15:0]        LEAK_RST   = 16'd131;
  localparam logic [15:0]        DECAY_RST  = 16'd262;

  typedef enum logic [2:0] {
    REG_THRESH,
    REG_RESET_V,
    REG_LEAK,
    REG_DECAY,
    REG_BG_GAIN,
    REG_REC_GAIN,
    REG_NMDA_GAIN,
    REG_GABA_GAIN
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] spike_threshold;
    logic signed [15:0] reset_voltage;
    logic [15:0]        leak_rate;
    logic [15:0]        gaba_decay;
    logic [15:0]        bg_ampa_gain;
    logic [15:0]        rec_ampa_gain;
    logic [15:0]        nmda_gain;
    logic [15:0]        gaba_gain;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [V_W-1:0]   v;
    logic [G_W-1:0]   g;
  } wb_t;

  // restoring long division, used only while building constant tables
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // lower-edge voltage of table entry i
  function automatic longint tab_ve(input int unsigned i, input int unsigned depth);
    logic [63:0] q;
    q = udiv(64'(i) * 64'd65536, 64'(depth));
    return longint'(q) - 64'sd32768;
  endfunction

  // magnesium block 1/(1 + exp(K*v)/3.57), Q0.16
  function automatic logic [15:0] block_at(input longint ve);
    longint      z;
    longint      nn;
    longint      nneg;
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] d;
    logic [63:0] b;
    z    = (-ve * 64'sd5862) >>> 8;
    nn   = z >>> 16;
    nneg = -nn;
    f    = {48'b0, z[15:0]};
    p    = (f * 64'd5143) >> 16;
    p    = (f * (64'd14812 + p)) >> 16;
    p    = (f * (64'd45580 + p)) >> 16;
    p    = p + 64'd65536;
    if (nn >= 0) begin
      m = ((p << nn[4:0]) * 64'd18358) >> 16;
    end else begin
      m = ((p * 64'd18358) >> 16) >> nneg[5:0];
    end
    d = 64'd65536 + m;
    b = udiv((64'd1 << 32) + (d >> 1), d);
    return (b > 64'd65535) ? 16'hFFFF : b[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lif_neuron_pool_update_unit.sv @@
// Conductance-based LIF neuron pool: each input word advances one neuron by one
// time step and yields one output word after the five update stages and an
// output register. One word per cycle is sustained while successive words name
// different neurons and out_tready is not held low; a word whose neuron is still
// in the five update stages waits until that neuron's write-back.
// After reset every entry of the voltage and gate memories is initialized;
// meanwhile no input word is taken (register writes still are).
`default_nettype none
module lif_neuron_pool_update_unit #(
  parameter int unsigned NEURONS   = lifp_pkg::NEURONS_DEF,
  parameter int unsigned TAB_DEPTH = lifp_pkg::TAB_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // neuron_index[9:0], bg_ampa_drive[25:10], rec_ampa_drive[41:26],
  // nmda_drive[57:42], gaba_drive[73:58]
  input  wire logic [lifp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // neuron_out[9:0], spiked[10], new_voltage[26:11], pooled_gaba[52:27]
  output logic      [lifp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tlast,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lifp_pkg::PADDR_W-1:0]    cfg_paddr,
  input  wire logic [lifp_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic      [lifp_pkg::PDATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  lifp_pkg::cfg_t           cfg;
  lifp_pkg::wb_t            wb;
  logic                     clearing;
  logic                     rd_en;
  logic [lifp_pkg::IDX_W-1:0] rd_idx;
  logic [lifp_pkg::V_W-1:0] rd_v;
  logic [lifp_pkg::G_W-1:0] rd_g;

  assign cfg_pready = 1'b1;

  lifp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  lifp_state #(.NEURONS(NEURONS)) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_v     (rd_v),
    .rd_g     (rd_g),
    .wb       (wb),
    .clearing (clearing)
  );

  lifp_datapath #(.NEURONS(NEURONS), .TAB_DEPTH(TAB_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .clearing   (clearing),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .rd_en      (rd_en),
    .rd_idx     (rd_idx),
    .rd_v       (rd_v),
    .rd_g       (rd_g),
    .wb         (wb),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // pooled sum only shows on the closing word of a step
  a_pool_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[52:27] == 26'd0)
    else $error("pooled sum on a non-closing word");

  // a spiking neuron reports the reset voltage
  a_spike_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[26:11] == cfg.reset_voltage)
    else $error("spike without reset voltage");

  // no word enters while the state memories initialize
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready && !wb.en)
    else $error("access during memory initialization");

endmodule
`default_nettype wire

@@ rtl/core/lifp_cfg.sv @@
`default_nettype none
module lifp_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lifp_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lifp_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lifp_pkg::PDATA_W-1:0]  prdata,
  output lifp_pkg::cfg_t                     cfg
);

  lifp_pkg::cfg_t   cfg_r;
  lifp_pkg::reg_idx_t sel;
  logic [15:0]      rd_val;
  logic             wr;

  assign sel = lifp_pkg::reg_idx_t'(paddr[4:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spike_threshold <= lifp_pkg::THRESH_RST;
      cfg_r.reset_voltage   <= lifp_pkg::RESET_V_RST;
      cfg_r.leak_rate       <= lifp_pkg::LEAK_RST;
      cfg_r.gaba_decay      <= lifp_pkg::DECAY_RST;
      cfg_r.bg_ampa_gain    <= '0;
      cfg_r.rec_ampa_gain   <= '0;
      cfg_r.nmda_gain       <= '0;
      cfg_r.gaba_gain       <= '0;
    end else if (wr) begin
      case (sel)
        lifp_pkg::REG_THRESH:    cfg_r.spike_threshold <= pwdata[15:0];
        lifp_pkg::REG_RESET_V:   cfg_r.reset_voltage   <= pwdata[15:0];
        lifp_pkg::REG_LEAK:      cfg_r.leak_rate       <= pwdata[15:0];
        lifp_pkg::REG_DECAY:     cfg_r.gaba_decay      <= pwdata[15:0];
        lifp_pkg::REG_BG_GAIN:   cfg_r.bg_ampa_gain    <= pwdata[15:0];
        lifp_pkg::REG_REC_GAIN:  cfg_r.rec_ampa_gain   <= pwdata[15:0];
        lifp_pkg::REG_NMDA_GAIN: cfg_r.nmda_gain       <= pwdata[15:0];
        lifp_pkg::REG_GABA_GAIN: cfg_r.gaba_gain       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      lifp_pkg::REG_THRESH:    rd_val = cfg_r.spike_threshold;
      lifp_pkg::REG_RESET_V:   rd_val = cfg_r.reset_voltage;
      lifp_pkg::REG_LEAK:      rd_val = cfg_r.leak_rate;
      lifp_pkg::REG_DECAY:     rd_val = cfg_r.gaba_decay;
      lifp_pkg::REG_BG_GAIN:   rd_val = cfg_r.bg_ampa_gain;
      lifp_pkg::REG_REC_GAIN:  rd_val = cfg_r.rec_ampa_gain;
      lifp_pkg::REG_NMDA_GAIN: rd_val = cfg_r.nmda_gain;
      lifp_pkg::REG_GABA_GAIN: rd_val = cfg_r.gaba_gain;
      default:                 rd_val = '0;
    endcase
  end

  assign prdata = {16'b0, rd_val};
  assign cfg    = cfg_r;

endmodule
`default_nettype wire

@@ rtl/core/lifp_state.sv @@
`default_nettype none
module lifp_state #(
  parameter int unsigned NEURONS = lifp_pkg::NEURONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [lifp_pkg::IDX_W-1:0]  rd_idx,
  output logic      [lifp_pkg::V_W-1:0]    rd_v,
  output logic      [lifp_pkg::G_W-1:0]    rd_g,
  input  wire lifp_pkg::wb_t               wb,
  output logic                             clearing
);

  localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned CW = $clog2(NEURONS + 1);

  logic [lifp_pkg::V_W-1:0] mem_v [NEURONS];
  logic [lifp_pkg::G_W-1:0] mem_g [NEURONS];
  logic [lifp_pkg::V_W-1:0] rd_v_r;
  logic [lifp_pkg::G_W-1:0] rd_g_r;
  logic [CW-1:0]            clr_cnt_r;
  logic                     clearing_r;

  // initialize every entry after reset, one per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + CW'(1);
      if (clr_cnt_r == CW'(NEURONS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_v[clr_cnt_r[AW-1:0]] <= lifp_pkg::V_INIT;
      mem_g[clr_cnt_r[AW-1:0]] <= '0;
    end else if (wb.en) begin
      mem_v[AW'(wb.idx)] <= wb.v;
      mem_g[AW'(wb.idx)] <= wb.g;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_v_r <= mem_v[AW'(rd_idx)];
      rd_g_r <= mem_g[AW'(rd_idx)];
    end
  end

  assign rd_v     = rd_v_r;
  assign rd_g     = rd_g_r;
  assign clearing = clearing_r;

endmodule
`default_nettype wire

@@ rtl/core/lifp_datapath.sv @@
`default_nettype none
module lifp_datapath #(
  parameter int unsigned NEURONS   = lifp_pkg::NEURONS_DEF,
  parameter int unsigned TAB_DEPTH = lifp_pkg::TAB_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lifp_pkg::cfg_t                 cfg,
  input  wire logic                           clearing,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lifp_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  output logic                                rd_en,
  output logic      [lifp_pkg::IDX_W-1:0]     rd_idx,
  input  wire logic [lifp_pkg::V_W-1:0]       rd_v,
  input  wire logic [lifp_pkg::G_W-1:0]       rd_g,
  output lifp_pkg::wb_t                       wb,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [lifp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                out_tlast
);

  localparam int unsigned TW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int unsigned ACC_W = 54;

  typedef struct packed {
    logic [lifp_pkg::IDX_W-1:0] idx;
    logic                       last;
    logic                       inr;
  } tag_t;

  // magnesium block table, built at elaboration
  logic [15:0] blk_tab [TAB_DEPTH];
  for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
    localparam logic [15:0] ENT =
      lifp_pkg::block_at(lifp_pkg::tab_ve(gi, TAB_DEPTH));
    assign blk_tab[gi] = ENT;
  end

  // input word
  logic [9:0]  in_idx;
  logic [15:0] in_bg, in_rec, in_nm, in_gb;
  logic        in_inr, in_fire, hazard;
  assign in_idx = in_tdata[9:0];
  assign in_bg  = in_tdata[25:10];
  assign in_rec = in_tdata[41:26];
  assign in_nm  = in_tdata[57:42];
  assign in_gb  = in_tdata[73:58];
  assign in_inr = {7'b0, in_idx} < 17'(NEURONS);

  // stage registers
  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, o_v_r;
  tag_t        s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic [15:0] s1_bg_r, s1_rec_r, s1_nm_r, s1_gb_r;

  logic signed [15:0] s2_vm_r, s3_vm_r, s4_vm_r;
  logic [15:0]        s2_g_r, s3_g_r, s4_g_r, s5_g_r;
  logic [31:0]        s2_pbg_r, s2_prec_r, s2_pnm_r, s2_pgb_r;
  logic [15:0]        s2_blk_r;

  logic signed [ACC_W-1:0] s3_tleak_r, s3_tbg_r, s3_trec_r, s3_tgb_r;
  logic [31:0]             s3_gnm_r;

  logic signed [49:0]      s4_tnm_r;
  logic signed [ACC_W-1:0] s4_part_r;

  logic signed [15:0] s5_nv_r;

  logic [9:0]  o_idx_r;
  logic        o_spk_r, o_last_r;
  logic [15:0] o_v_out_r;
  logic [25:0] o_pool_r;
  logic [25:0] sum_r;

  logic o_rdy, s5_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  assign o_rdy  = !o_v_r  | out_tready;
  assign s5_rdy = !s5_v_r | o_rdy;
  assign s4_rdy = !s4_v_r | s5_rdy;
  assign s3_rdy = !s3_v_r | s4_rdy;
  assign s2_rdy = !s2_v_r | s3_rdy;
  assign s1_rdy = !s1_v_r | s2_rdy;

  // hold a word whose neuron is still between read and write-back
  assign hazard = (s1_v_r & s1_tag_r.inr & (s1_tag_r.idx == in_idx))
                | (s2_v_r & s2_tag_r.inr & (s2_tag_r.idx == in_idx))
                | (s3_v_r & s3_tag_r.inr & (s3_tag_r.idx == in_idx))
                | (s4_v_r & s4_tag_r.inr & (s4_tag_r.idx == in_idx))
                | (s5_v_r & s5_tag_r.inr & (s5_tag_r.idx == in_idx));

  assign in_tready = !clearing & s1_rdy & !hazard;
  assign in_fire   = in_tvalid & in_tready;
  assign rd_en     = in_fire & in_inr;
  assign rd_idx    = in_idx;

  // stage 1: gain products and block lookup
  logic signed [15:0] s1_vm;
  logic [15:0]        s1_vu;
  logic [31:0]        s1_tprod;
  logic [15:0]        s1_tfull;
  logic [TW-1:0]      s1_ti;
  assign s1_vm    = rd_v;
  assign s1_vu    = {~rd_v[15], rd_v[14:0]};
  assign s1_tprod = 32'(s1_vu) * 32'(TAB_DEPTH);
  assign s1_tfull = s1_tprod[31:16];
  assign s1_ti    = (32'(s1_tfull) >= 32'(TAB_DEPTH)) ? TW'(TAB_DEPTH - 1)
                                                       : s1_tfull[TW-1:0];

  // stage 2: driving-force products
  logic signed [16:0] s2_de;
  logic signed [17:0] s2_di;
  logic signed [34:0] s2_leak;
  logic [47:0]        s2_gnm;
  assign s2_de   = 17'(s2_vm_r);
  assign s2_di   = 18'(s2_vm_r) - 18'(lifp_pkg::VI_Q);
  assign s2_leak = $signed({1'b0, cfg.leak_rate}) * s2_di;
  assign s2_gnm  = 48'(s2_pnm_r) * 48'(s2_blk_r);

  // stage 3: NMDA product and partial sum
  logic signed [16:0]      s3_de;
  logic signed [49:0]      s3_tnm;
  logic signed [ACC_W-1:0] s3_part;
  assign s3_de   = 17'(s3_vm_r);
  assign s3_tnm  = $signed({1'b0, s3_gnm_r}) * s3_de;
  assign s3_part = s3_tleak_r + s3_tbg_r + s3_trec_r + s3_tgb_r;

  // stage 4: round, subtract, saturate
  logic signed [ACC_W-1:0] s4_acc;
  logic signed [29:0]      s4_dv;
  logic signed [31:0]      s4_nv;
  logic signed [15:0]      s4_nvs;
  assign s4_acc = s4_part_r + ACC_W'(s4_tnm_r) + ACC_W'(64'sd8388608);
  assign s4_dv  = s4_acc[ACC_W-1:24];
  assign s4_nv  = 32'(s4_vm_r) - 32'(s4_dv);
  always_comb begin
    if (s4_nv > 32'sd32767) begin
      s4_nvs = 16'sh7FFF;
    end else if (s4_nv < -32'sd32768) begin
      s4_nvs = 16'sh8000;
    end else begin
      s4_nvs = s4_nv[15:0];
    end
  end

  // stage 5: spike, gate update, pooled sum
  logic        s5_spk;
  logic [15:0] s5_vf;
  logic [16:0] s5_gup;
  logic [15:0] s5_gs;
  logic [32:0] s5_dec;
  logic [15:0] s5_gn;
  logic [26:0] s5_sadd;
  logic [25:0] s5_base, s5_pool, sum_nxt;
  assign s5_spk  = s5_tag_r.inr & (s5_nv_r > cfg.spike_threshold);
  assign s5_vf   = s5_spk ? cfg.reset_voltage : s5_nv_r;
  assign s5_gup  = {1'b0, s5_g_r} + 17'd256;
  assign s5_gs   = !s5_spk ? s5_g_r : (s5_gup[16] ? 16'hFFFF : s5_gup[15:0]);
  assign s5_dec  = 33'(32'(cfg.gaba_decay) * 32'(s5_gs)) + 33'd32768;
  assign s5_gn   = s5_gs - s5_dec[31:16];
  assign s5_sadd = {1'b0, sum_r} + 27'(s5_gn);
  assign s5_base = !s5_tag_r.inr ? sum_r : (s5_sadd[26] ? lifp_pkg::SUM_MAX : s5_sadd[25:0]);
  assign s5_pool = s5_tag_r.last ? s5_base : '0;
  assign sum_nxt = s5_tag_r.last ? '0 : s5_base;

  assign wb.en  = s5_v_r & o_rdy & s5_tag_r.inr;
  assign wb.idx = s5_tag_r.idx;
  assign wb.v   = s5_vf;
  assign wb.g   = s5_gn;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      o_v_r  <= 1'b0;
      sum_r  <= '0;
    end else begin
      if (s1_rdy) s1_v_r <= in_fire;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s5_rdy) s5_v_r <= s4_v_r;
      if (o_rdy)  o_v_r  <= s5_v_r;
      if (s5_v_r && o_rdy) sum_r <= sum_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag_r <= '{idx: in_idx, last: in_tlast, inr: in_inr};
      s1_bg_r  <= in_bg;
      s1_rec_r <= in_rec;
      s1_nm_r  <= in_nm;
      s1_gb_r  <= in_gb;
    end
    if (s1_v_r && s2_rdy) begin
      s2_tag_r  <= s1_tag_r;
      s2_vm_r   <= s1_vm;
      s2_g_r    <= rd_g;
      s2_pbg_r  <= 32'(cfg.bg_ampa_gain) * 32'(s1_bg_r);
      s2_prec_r <= 32'(cfg.rec_ampa_gain) * 32'(s1_rec_r);
      s2_pnm_r  <= 32'(cfg.nmda_gain) * 32'(s1_nm_r);
      s2_pgb_r  <= 32'(cfg.gaba_gain) * 32'(s1_gb_r);
      s2_blk_r  <= blk_tab[s1_ti];
    end
    if (s2_v_r && s3_rdy) begin
      s3_tag_r   <= s2_tag_r;
      s3_vm_r    <= s2_vm_r;
      s3_g_r     <= s2_g_r;
      s3_tleak_r <= ACC_W'(s2_leak) <<< 8;
      s3_tbg_r   <= ACC_W'($signed({1'b0, s2_pbg_r}) * s2_de);
      s3_trec_r  <= ACC_W'($signed({1'b0, s2_prec_r}) * s2_de);
      s3_tgb_r   <= ACC_W'($signed({1'b0, s2_pgb_r}) * s2_di);
      s3_gnm_r   <= s2_gnm[47:16];
    end
    if (s3_v_r && s4_rdy) begin
      s4_tag_r  <= s3_tag_r;
      s4_vm_r   <= s3_vm_r;
      s4_g_r    <= s3_g_r;
      s4_tnm_r  <= s3_tnm;
      s4_part_r <= s3_part;
    end
    if (s4_v_r && s5_rdy) begin
      s5_tag_r <= s4_tag_r;
      s5_g_r   <= s4_g_r;
      s5_nv_r  <= s4_nvs;
    end
    if (s5_v_r && o_rdy) begin
      o_idx_r   <= s5_tag_r.idx;
      o_spk_r   <= s5_spk;
      o_v_out_r <= s5_tag_r.inr ? s5_vf : 16'd0;
      o_pool_r  <= s5_pool;
      o_last_r  <= s5_tag_r.last;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {3'b0, o_pool_r, o_v_out_r, o_spk_r, o_idx_r};
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

@@ sim/lif_pool_checker.sv @@
`timescale 1ns / 100ps
module lif_pool_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [lifp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [lifp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                            out_tlast,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lifp_pkg::PADDR_W-1:0]    cfg_paddr,
  input  wire logic [lifp_pkg::PDATA_W-1:0]    cfg_pwdata,
  input  wire logic                            cfg_pready,
  output int                                   fail_count,
  output int                                   pending_words
);
  import lifp_pkg::*;

  localparam int POOL = 1024;
  localparam int TAB = 256;

  typedef struct {
    logic [9:0]  nrn;
    logic        spk;
    logic [15:0] volt;
    logic [25:0] pool_sum;
    logic        done;
  } nrn_result_t;

  logic [15:0] mg_tab [TAB];
  logic [15:0] volt_mem [POOL];
  logic [15:0] gate_mem [POOL];
  logic [25:0] gate_sum;
  logic [15:0] regs [8];
  nrn_result_t due_q [$];

  assign pending_words = due_q.size();

  // magnesium block at voltage ve, Q0.16
  function automatic logic [15:0] mg_block(input longint ve);
    longint z, n;
    logic [63:0] f, p, m, d, b;
    z = (-ve * 64'sd5862) >>> 8;
    n = z >>> 16;
    f = 64'(z - n * 65536);
    p = (f * 64'd5143) >> 16;
    p = (f * (64'd14812 + p)) >> 16;
    p = (f * (64'd45580 + p)) >> 16;
    p = p + 64'd65536;
    if (n >= 0) begin
      m = ((p << (n & 31)) * 64'd18358) >> 16;
    end else begin
      m = ((p * 64'd18358) >> 16) >> ((-n) & 63);
    end
    d = 64'd65536 + m;
    b = ((64'd1 << 32) + d / 2) / d;
    return (b > 64'd65535) ? 16'hFFFF : b[15:0];
  endfunction

  initial begin
    for (int i = 0; i < TAB; i++) mg_tab[i] = mg_block(longint'(i) * 256 - 32768);
  end

  // advance one neuron and return its result word
  function automatic nrn_result_t advance_neuron(input logic [IN_DATA_W-1:0] d,
                                                 input logic last);
    nrn_result_t r;
    logic [9:0] idx;
    longint v, acc, dv, nv, gnm;
    longint bg, rec, nm, gb;
    logic [63:0] g;
    idx = d[9:0];
    bg  = longint'(d[25:10]);
    rec = longint'(d[41:26]);
    nm  = longint'(d[57:42]);
    gb  = longint'(d[73:58]);
    v   = longint'($signed(volt_mem[idx]));
    gnm = longint'((64'(regs[REG_NMDA_GAIN]) * 64'(nm) * 64'(mg_tab[8'((v + 32768) >> 8)])) >> 16);
    acc = longint'(regs[REG_LEAK]) * (v + 17920) * 256;
    acc += longint'(regs[REG_BG_GAIN]) * bg * v;
    acc += longint'(regs[REG_REC_GAIN]) * rec * v;
    acc += gnm * v;
    acc += longint'(regs[REG_GABA_GAIN]) * gb * (v + 17920);
    dv = (acc + (64'sd1 <<< 23)) >>> 24;
    nv = v - dv;
    if (nv > 32767) nv = 32767;
    if (nv < -32768) nv = -32768;
    g = 64'(gate_mem[idx]);
    r.spk = 1'b0;
    if (nv > longint'($signed(regs[REG_THRESH]))) begin
      nv = longint'($signed(regs[REG_RESET_V]));
      r.spk = 1'b1;
      g = g + 256;
      if (g > 65535) g = 65535;
    end
    g = g - ((64'(regs[REG_DECAY]) * g + 32768) >> 16);
    gate_mem[idx] = g[15:0];
    volt_mem[idx] = nv[15:0];
    if (64'(gate_sum) + g > 64'(SUM_MAX)) gate_sum = SUM_MAX;
    else gate_sum = gate_sum + g[25:0];
    r.nrn = idx;
    r.volt = nv[15:0];
    r.done = last;
    r.pool_sum = last ? gate_sum : '0;
    if (last) gate_sum = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    nrn_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL; i++) begin
        volt_mem[i] = V_INIT;
        gate_mem[i] = '0;
      end
      gate_sum = '0;
      regs[REG_THRESH]    = THRESH_RST;
      regs[REG_RESET_V]   = RESET_V_RST;
      regs[REG_LEAK]      = LEAK_RST;
      regs[REG_DECAY]     = DECAY_RST;
      regs[REG_BG_GAIN]   = '0;
      regs[REG_REC_GAIN]  = '0;
      regs[REG_NMDA_GAIN] = '0;
      regs[REG_GABA_GAIN] = '0;
      due_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        regs[cfg_paddr[4:2]] = cfg_pwdata[15:0];
      if (in_tvalid && in_tready)
        due_q.insert(due_q.size(), advance_neuron(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result word: neuron_out %0d", out_tdata[9:0]);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (out_tdata[9:0] !== want.nrn) begin
            $error("neuron_out expected %0d got %0d", want.nrn, out_tdata[9:0]);
            fail_count++;
          end
          if (out_tdata[10] !== want.spk) begin
            $error("spiked expected %0d got %0d", want.spk, out_tdata[10]);
            fail_count++;
          end
          if (out_tdata[26:11] !== want.volt) begin
            $error("new_voltage expected %0d got %0d", $signed(want.volt),
                   $signed(out_tdata[26:11]));
            fail_count++;
          end
          if (out_tdata[52:27] !== want.pool_sum) begin
            $error("pooled_gaba expected %0d got %0d", want.pool_sum, out_tdata[52:27]);
            fail_count++;
          end
          if (out_tlast !== want.done) begin
            $error("step_done expected %0d got %0d", want.done, out_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ sim/tb_lif_neuron_pool_update_unit.sv @@
`timescale 1ns / 100ps
module tb_lif_neuron_pool_update_unit;
  import lifp_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // neuron_index[9:0], bg_ampa_drive[25:10], rec_ampa_drive[41:26],
  // nmda_drive[57:42], gaba_drive[73:58]
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // neuron_out[9:0], spiked[10], new_voltage[26:11], pooled_gaba[52:27]
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]     cfg_paddr = '0;
  logic [PDATA_W-1:0]     cfg_pwdata = '0;
  logic [PDATA_W-1:0]     cfg_prdata;
  logic                   cfg_pready;
  int                     fail_count;
  int                     pending_words;
  int                     send_idle_pct = 0;
  int                     stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lif_neuron_pool_update_unit dut (.*);

  lif_pool_checker u_checker (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic put_word(input logic [9:0] idx, input logic [15:0] bg,
                          input logic [15:0] rec, input logic [15:0] nm,
                          input logic [15:0] gb, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, gb, nm, rec, bg, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'({r, 2'b00});
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] thr, input logic [15:0] rv,
                              input logic [15:0] leak, input logic [15:0] dec,
                              input logic [15:0] bgg, input logic [15:0] recg,
                              input logic [15:0] nmg, input logic [15:0] gbg);
    write_reg(REG_THRESH, thr);
    write_reg(REG_RESET_V, rv);
    write_reg(REG_LEAK, leak);
    write_reg(REG_DECAY, dec);
    write_reg(REG_BG_GAIN, bgg);
    write_reg(REG_REC_GAIN, recg);
    write_reg(REG_NMDA_GAIN, nmg);
    write_reg(REG_GABA_GAIN, gbg);
  endtask

  task automatic random_setting();
    if ($urandom_range(4) == 0)
      load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      load_setting(16'($urandom_range(3000, 9000)) ^ 16'hFFFF,
                   16'($urandom_range(11000, 18000)) ^ 16'hFFFF,
                   16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
  endtask

  // mostly whole time steps over a run of neurons, the rest raw noise
  task automatic run_traffic(input int count);
    int sent, len, amp;
    logic [9:0] base;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        len  = $urandom_range(1, 24);
        base = 10'($urandom);
        amp  = ($urandom_range(3) == 0) ? 65535 : $urandom_range(200, 6000);
        for (int i = 0; i < len; i++)
          put_word(base + 10'(i), 16'($urandom_range(0, amp)),
                   16'($urandom_range(0, amp)), 16'($urandom_range(0, amp)),
                   16'($urandom_range(0, amp)),
                   (i == len - 1) && ($urandom_range(19) != 0));
        sent += len;
      end else begin
        put_word(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // extreme gains, no spike possible
    load_setting(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_word(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    put_word(10'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd2, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd3, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    put_word(10'd4, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    put_word(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    put_word(10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    settle();
    // every neuron fires, gates grow without decay
    load_setting(16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_word(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    put_word(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    put_word(10'd5, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0);
    put_word(10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    put_word(10'd6, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    settle();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 57 : 0;
      stall_pct     = (ph == 0) ? 57 : (ph == 1) ? 36 : 0;
      for (int h = 0; h < 2; h++) begin
        random_setting();
        run_traffic(310);
        settle();
      end
    end
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
